// ----- rtl/sem_pkg.sv -----
// Shared types, constants and register codes of the Sobel edge magnitude unit.
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH_DEFAULT = 2048;

  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_THRESH_W = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam int PIXEL_W   = 8;
  localparam int OUT_ROW_W = 16;
  localparam int OUT_COL_W = 11;
  localparam int GRAD_W    = 11;
  localparam int SQ_W      = 20;
  localparam int NORM_W    = 21;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CFG_THRESH_W-1:0] THRESH_RESET = 8'd70;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_index_e;

  // One window result handed from the front part to the back part.
  typedef struct packed {
    logic signed [GRAD_W-1:0] sx;
    logic signed [GRAD_W-1:0] sy;
    logic                     border;
    logic [OUT_ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0]     col;
    logic                     frame_end;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/sem_front.sv -----
// Front part: pixel intake, line store, 3x3 window, position counters and gradients.
`default_nettype none

module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [sem_pkg::CFG_WIDTH_W-1:0]  cfg_width_i,
  input  wire logic [sem_pkg::CFG_HEIGHT_W-1:0] cfg_height_i,
  input  wire logic                             pixel_valid_i,
  output logic                                  pixel_ready_o,
  input  wire logic [sem_pkg::PIXEL_W-1:0]      gray_pixel_i,
  output logic                                  item_valid_o,
  input  wire logic                             item_ready_i,
  output sem_pkg::item_t                        item_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = (CW + 1 > sem_pkg::CFG_WIDTH_W) ? CW + 1 : sem_pkg::CFG_WIDTH_W;
  localparam int OCW = (CW > sem_pkg::OUT_COL_W) ? CW : sem_pkg::OUT_COL_W;
  localparam int HW  = sem_pkg::CFG_HEIGHT_W;
  localparam int PW  = sem_pkg::PIXEL_W;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_CALC = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;

  // Each entry holds {row before previous, previous row} of one column.
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_data_q;

  logic [PW-1:0] win_q [6];
  logic [PW-1:0] pix_q;
  logic [CW-1:0] col_q;
  logic [HW-1:0] row_q;

  logic [EW-1:0] width_ext, eff_width, col_next_ext;
  logic [HW:0]   eff_height, row_next_ext;
  logic          last_col, last_row, emit, retire;
  logic [PW-1:0] p00, p10, p20, p01, p21, p02, p12, p22;
  logic [PW+1:0] sum_right, sum_left, sum_bottom, sum_top;
  logic [OCW-1:0] ocol;

  assign width_ext = EW'(cfg_width_i);

  always_comb begin
    if (width_ext < EW'(3)) begin
      eff_width = EW'(3);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    if (cfg_height_i < HW'(3)) begin
      eff_height = (HW+1)'(3);
    end else begin
      eff_height = {1'b0, cfg_height_i};
    end
  end

  assign col_next_ext = EW'(col_q) + EW'(1);
  assign row_next_ext = {1'b0, row_q} + (HW+1)'(1);
  assign last_col     = col_next_ext >= eff_width;
  assign last_row     = row_next_ext >= eff_height;
  assign emit         = (row_q != '0) && (col_q != '0);

  assign p00 = win_q[0];
  assign p10 = win_q[1];
  assign p20 = win_q[2];
  assign p01 = win_q[3];
  assign p21 = win_q[5];
  assign p02 = rd_data_q[2*PW-1:PW];
  assign p12 = rd_data_q[PW-1:0];
  assign p22 = pix_q;

  assign sum_right  = (PW+2)'(p02) + {1'b0, p12, 1'b0} + (PW+2)'(p22);
  assign sum_left   = (PW+2)'(p00) + {1'b0, p10, 1'b0} + (PW+2)'(p20);
  assign sum_bottom = (PW+2)'(p20) + {1'b0, p21, 1'b0} + (PW+2)'(p22);
  assign sum_top    = (PW+2)'(p00) + {1'b0, p01, 1'b0} + (PW+2)'(p02);

  assign ocol = OCW'(col_q) - OCW'(1);

  always_comb begin
    item_o.sx        = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    item_o.sy        = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
    item_o.border    = (row_q == HW'(1)) || (col_q == CW'(1));
    item_o.row       = row_q - HW'(1);
    item_o.col       = ocol[sem_pkg::OUT_COL_W-1:0];
    item_o.frame_end = last_row && last_col;
  end

  // Hold the window in CALC until the queue takes the item.
  assign retire        = (state_q == F_CALC) && (!emit || item_ready_i);
  assign item_valid_o  = (state_q == F_CALC) && emit;
  assign pixel_ready_o = (state_q == F_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (pixel_valid_i) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        if (retire) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      line_mem[col_q] <= {p12, pix_q};
    end
    if (pixel_ready_o && pixel_valid_i) begin
      rd_data_q <= line_mem[col_q];
      pix_q     <= gray_pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (retire) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= p02;
        win_q[4] <= p12;
        win_q[5] <= pix_q;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_next_ext[HW-1:0];
        end else begin
          col_q <= col_next_ext[CW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sem_queue.sv -----
// Two-entry queue that decouples the window front part from the magnitude back part.
`default_nettype none

module sem_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire sem_pkg::item_t  push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output sem_pkg::item_t       pop_item_o
);

  sem_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sem_back.sv -----
// Back part: squared norm, ceiling square root by binary search, threshold, output register.
`default_nettype none

module sem_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [sem_pkg::CFG_THRESH_W-1:0] cfg_thresh_i,
  input  wire logic                             item_valid_i,
  output logic                                  item_ready_o,
  input  wire sem_pkg::item_t                   item_i,
  output logic                                  edge_valid_o,
  input  wire logic                             edge_ready_i,
  output logic [sem_pkg::PIXEL_W-1:0]           edge_value_o,
  output logic [sem_pkg::OUT_ROW_W-1:0]         out_row_o,
  output logic [sem_pkg::OUT_COL_W-1:0]         out_col_o,
  output logic                                  frame_end_o
);

  localparam int PW = sem_pkg::PIXEL_W;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SUM  = 4'b0010,
    B_SRCH = 4'b0100,
    B_DONE = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [sem_pkg::SQ_W-1:0]      sq_x_q, sq_y_q;
  logic [sem_pkg::NORM_W-1:0]    norm_q;
  logic [PW-1:0]                 lo_q, hi_q;
  logic [sem_pkg::OUT_ROW_W-1:0] row_q;
  logic [sem_pkg::OUT_COL_W-1:0] col_q;
  logic                          fend_q;
  logic                          out_valid_q;

  logic signed [2*sem_pkg::GRAD_W-1:0] prod_x, prod_y;
  logic [PW:0]     mid_sum;
  logic [PW-1:0]   mid;
  logic [2*PW-1:0] mid_sq;
  logic            mid_ge, out_free;

  assign prod_x  = item_i.sx * item_i.sx;
  assign prod_y  = item_i.sy * item_i.sy;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[PW:1];
  assign mid_sq  = mid * mid;
  assign mid_ge  = sem_pkg::NORM_W'(mid_sq) >= norm_q;

  assign out_free     = !out_valid_q || edge_ready_i;
  assign item_ready_o = (state_q == B_IDLE);
  assign edge_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (item_valid_i) begin
          state_d = B_SUM;
        end
      end
      B_SUM: state_d = B_SRCH;
      B_SRCH: begin
        if (lo_q == hi_q) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        // Border pixels search a zero norm, which lands on zero.
        sq_x_q <= item_i.border ? '0 : prod_x[sem_pkg::SQ_W-1:0];
        sq_y_q <= item_i.border ? '0 : prod_y[sem_pkg::SQ_W-1:0];
        row_q  <= item_i.row;
        col_q  <= item_i.col;
        fend_q <= item_i.frame_end;
      end
      B_SUM: begin
        norm_q <= sem_pkg::NORM_W'(sq_x_q) + sem_pkg::NORM_W'(sq_y_q);
        lo_q   <= '0;
        hi_q   <= '1;
      end
      B_SRCH: begin
        if (lo_q != hi_q) begin
          if (mid_ge) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid + PW'(1);
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          edge_value_o <= (lo_q <= cfg_thresh_i) ? '0 : lo_q;
          out_row_o    <= row_q;
          out_col_o    <= col_q;
          frame_end_o  <= fend_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (edge_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sobel_edge_magnitude_threshold_unit.sv -----
// Top level of the Sobel edge magnitude unit: configuration registers and part wiring.
//
// Pixels enter in raster order on the pixel channel (gray_pixel_i, valid/ready).
// A pixel at input row 0 or column 0 gives no result; every other pixel gives
// one result on the edge channel for the window centered one row up and one
// column left, with that position on out_row_o/out_col_o and frame_end_o set
// on the last pixel of the image. Results on the outer ring are 0.
// The front part handles a pixel as a line store read, then a window update
// that waits for the queue to take any item it emits; no new pixel is taken before.
// The back part takes an item, sums, runs 8 binary search steps of its 8x8
// multiplier, makes a final compare and writes the output register, and takes
// no new item until that result has entered the output register.
// A two-entry queue lets the front run ahead while the back works or the
// receiver stalls; a stalled result holds in the output register and backs
// up the queue, then the pixel channel drops ready.
// Reset clears the counters, the window and the configuration (width 640,
// height 480, threshold 70); line store contents are undefined until written.
// Write configuration only between frames while the block is empty.
`default_nettype none

module sobel_edge_magnitude_threshold_unit #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            pixel_valid_i,
  output logic                                 pixel_ready_o,
  input  wire logic [sem_pkg::PIXEL_W-1:0]     gray_pixel_i,
  output logic                                 edge_valid_o,
  input  wire logic                            edge_ready_i,
  output logic [sem_pkg::PIXEL_W-1:0]          edge_value_o,
  output logic [sem_pkg::OUT_ROW_W-1:0]        out_row_o,
  output logic [sem_pkg::OUT_COL_W-1:0]        out_col_o,
  output logic                                 frame_end_o
);

  logic [sem_pkg::CFG_WIDTH_W-1:0]  width_q;
  logic [sem_pkg::CFG_HEIGHT_W-1:0] height_q;
  logic [sem_pkg::CFG_THRESH_W-1:0] thresh_q;

  logic           front_valid, front_ready, back_valid, back_ready;
  sem_pkg::item_t front_item, back_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::WIDTH_RESET;
      height_q <= sem_pkg::HEIGHT_RESET;
      thresh_q <= sem_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      case (sem_pkg::cfg_index_e'(cfg_index_i))
        sem_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i[sem_pkg::CFG_WIDTH_W-1:0];
        sem_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i[sem_pkg::CFG_HEIGHT_W-1:0];
        sem_pkg::CFG_EDGE_THRESHOLD: thresh_q <= cfg_wdata_i[sem_pkg::CFG_THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .pixel_valid_i(pixel_valid_i),
    .pixel_ready_o(pixel_ready_o),
    .gray_pixel_i (gray_pixel_i),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  sem_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_item_i (front_item),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_item_o  (back_item)
  );

  sem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_thresh_i(thresh_q),
    .item_valid_i(back_valid),
    .item_ready_o(back_ready),
    .item_i      (back_item),
    .edge_valid_o(edge_valid_o),
    .edge_ready_i(edge_ready_i),
    .edge_value_o(edge_value_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

// ----- rtl/sem_checker.sv -----
// Port-level checks of the Sobel edge magnitude unit and their bind to the top level.
`default_nettype none

module sem_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             edge_valid_o,
  input wire logic                             edge_ready_i,
  input wire logic [sem_pkg::PIXEL_W-1:0]      edge_value_o,
  input wire logic [sem_pkg::OUT_ROW_W-1:0]    out_row_o,
  input wire logic [sem_pkg::OUT_COL_W-1:0]    out_col_o,
  input wire logic                             frame_end_o
);

  // A result waiting for the receiver keeps valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid_o && !edge_ready_i |=> edge_valid_o && $stable(edge_value_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // Reset empties the output register at once.
  assert property (@(posedge clk_i) !rst_ni |-> !edge_valid_o)
    else $error("result valid during reset");

  // The outer ring of the image reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid_o && (out_row_o == '0 || out_col_o == '0) |-> edge_value_o == '0)
    else $error("nonzero edge value on border");

endmodule

bind sobel_edge_magnitude_threshold_unit sem_checker u_sem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .edge_valid_o(edge_valid_o),
  .edge_ready_i(edge_ready_i),
  .edge_value_o(edge_value_o),
  .out_row_o   (out_row_o),
  .out_col_o   (out_col_o),
  .frame_end_o (frame_end_o)
);

`default_nettype wire

// ----- tb/sv/sobel_edge_magnitude_threshold_unit_tb.sv -----
// Self-checking testbench of the Sobel edge magnitude threshold unit.
module sobel_edge_magnitude_threshold_unit_tb;
  import sem_pkg::*;

  localparam int MAXW         = MAX_WIDTH_DEFAULT;
  localparam int ITEM_TARGET  = 1750;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 1_500_000;

  localparam int PIX_UNIFORM = 0;
  localparam int PIX_SOFT    = 1;
  localparam int PIX_BINARY  = 2;

  typedef struct packed {
    logic [PIXEL_W-1:0]   edge_value;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 frame_end;
  } edge_result_t;

  // Predicts edge results from accepted pixels and checks what comes out.
  class edge_scoreboard;
    logic [PIXEL_W-1:0]      prev_row [MAXW];
    logic [PIXEL_W-1:0]      older_row [MAXW];
    logic [PIXEL_W-1:0]      win [6];
    int                      col_pos;
    int                      row_pos;
    logic [CFG_WIDTH_W-1:0]  img_width;
    logic [CFG_HEIGHT_W-1:0] img_height;
    logic [CFG_THRESH_W-1:0] threshold;
    edge_result_t            pending_edges[$];
    int unsigned             mismatches;

    function new();
      for (int i = 0; i < MAXW; i++) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      img_width  = WIDTH_RESET;
      img_height = HEIGHT_RESET;
      threshold  = THRESH_RESET;
      mismatches = 0;
    endfunction

    function void set_config(cfg_index_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:    img_width  = data[CFG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT:   img_height = data[CFG_HEIGHT_W-1:0];
        CFG_EDGE_THRESHOLD: threshold  = data[CFG_THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    // Ceiling of the square root, saturated at the pixel maximum.
    function int unsigned ceil_root_sat(int unsigned n);
      int unsigned k;
      if (n > 255 * 255) return 255;
      k = 0;
      while (k * k < n) k++;
      return k;
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] pix);
      int w, h, c, r;
      int top_l, mid_l, bot_l, top_m, bot_m, top_r, mid_r, bot_r;
      int sx, sy;
      int unsigned mag;
      edge_result_t res;
      w = img_width;
      h = img_height;
      if (w < 3) w = 3;
      if (w > MAXW) w = MAXW;
      if (h < 3) h = 3;
      c = (col_pos >= MAXW) ? 0 : col_pos;
      r = row_pos;
      top_l = win[0]; mid_l = win[1]; bot_l = win[2];
      top_m = win[3];                 bot_m = win[5];
      top_r = older_row[c]; mid_r = prev_row[c]; bot_r = pix;
      if (r >= 1 && c >= 1) begin
        res.row        = OUT_ROW_W'(r - 1);
        res.col        = OUT_COL_W'(c - 1);
        res.edge_value = '0;
        // outer ring stays zero
        if (r - 1 != 0 && c - 1 != 0) begin
          sx  = (top_r + 2 * mid_r + bot_r) - (top_l + 2 * mid_l + bot_l);
          sy  = (bot_l + 2 * bot_m + bot_r) - (top_l + 2 * top_m + top_r);
          mag = ceil_root_sat(int'(sx * sx) + int'(sy * sy));
          if (mag > threshold) res.edge_value = PIXEL_W'(mag);
        end
        res.frame_end = (r + 1 >= h) && (c + 1 >= w);
        pending_edges.push_back(res);
      end
      // shift the window left and push the new column in
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = PIXEL_W'(top_r); win[4] = PIXEL_W'(mid_r); win[5] = pix;
      older_row[c] = prev_row[c];
      prev_row[c]  = pix;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_edge(logic [PIXEL_W-1:0] value, logic [OUT_ROW_W-1:0] row,
                             logic [OUT_COL_W-1:0] col, logic fe);
      edge_result_t want;
      if (pending_edges.size() == 0) begin
        log_mismatch($sformatf("unexpected edge result: value %0d row %0d col %0d end %b",
                               value, row, col, fe));
        return;
      end
      want = pending_edges.pop_front();
      if (value !== want.edge_value || row !== want.row || col !== want.col ||
          fe !== want.frame_end)
        log_mismatch($sformatf(
          "edge mismatch: exp value %0d row %0d col %0d end %b, got %0d %0d %0d %b",
          want.edge_value, want.row, want.col, want.frame_end, value, row, col, fe));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   pixel_valid_i;
  logic                   pixel_ready_o;
  logic [PIXEL_W-1:0]     gray_pixel_i;
  logic                   edge_valid_o;
  logic                   edge_ready_i;
  logic [PIXEL_W-1:0]     edge_value_o;
  logic [OUT_ROW_W-1:0]   out_row_o;
  logic [OUT_COL_W-1:0]   out_col_o;
  logic                   frame_end_o;

  edge_scoreboard sb = new();
  int items_sent  = 0;
  int tx_idle_max = 0;
  int rx_idle_max = 0;
  int cycle_count = 0;

  sobel_edge_magnitude_threshold_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .gray_pixel_i  (gray_pixel_i),
    .edge_valid_o  (edge_valid_o),
    .edge_ready_i  (edge_ready_i),
    .edge_value_o  (edge_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_end_o   (frame_end_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sobel_edge_magnitude_threshold_unit_tb: done, errors");
      $finish;
    end
  end

  // Watch both channels; values read here are the ones before this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pixel_valid_i && pixel_ready_o) sb.note_pixel(gray_pixel_i);
      if (edge_valid_o && edge_ready_i)
        sb.check_edge(edge_value_o, out_row_o, out_col_o, frame_end_o);
    end
  end

  // Result side: stall a random number of cycles, then take one transfer.
  initial begin
    int stall;
    edge_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_idle_max = 0;
          1:       rx_idle_max = 12;
          default: rx_idle_max = $urandom_range(1, 12);
        endcase
      end
      stall = $urandom_range(0, rx_idle_max);
      if (stall > 0) begin
        edge_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      edge_ready_i <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (edge_valid_o) break;
      end
      @(posedge clk_i);
    end
  end

  task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    if (gap > 0) begin
      pixel_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    gray_pixel_i  <= pix;
    // ready is settled between edges
    forever begin
      @(negedge clk_i);
      if (pixel_ready_o) break;
    end
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_cfg(input logic [CFG_DATA_W-1:0] width_data,
                           input logic [CFG_DATA_W-1:0] height_data,
                           input logic [CFG_DATA_W-1:0] thresh_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= width_data;
    @(posedge clk_i);
    sb.set_config(CFG_IMAGE_WIDTH, width_data);
    cfg_index_i <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= height_data;
    @(posedge clk_i);
    sb.set_config(CFG_IMAGE_HEIGHT, height_data);
    cfg_index_i <= CFG_EDGE_THRESHOLD;
    cfg_wdata_i <= thresh_data;
    @(posedge clk_i);
    sb.set_config(CFG_EDGE_THRESHOLD, thresh_data);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every expected result has come and the pipeline has drained.
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_frame(input logic [CFG_DATA_W-1:0] width_data,
                           input logic [CFG_DATA_W-1:0] height_data, input int style);
    int w, h, base;
    logic [PIXEL_W-1:0] pix;
    w = width_data[CFG_WIDTH_W-1:0];
    h = height_data;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    if (h < 3) h = 3;
    base = $urandom_range(0, 230);
    for (int i = 0; i < w * h; i++) begin
      case (style)
        PIX_SOFT:   pix = PIXEL_W'(base + $urandom_range(0, 25));
        PIX_BINARY: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:    pix = PIXEL_W'($urandom);
      endcase
      send_pixel(pix);
    end
    pixel_valid_i <= 1'b0;
  endtask

  initial begin
    logic [PIXEL_W-1:0]    corner_step [9];
    logic [CFG_DATA_W-1:0] wd, hd, td;
    bit big_done;
    int w_pick;

    corner_step = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    big_done      = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i   <= '0;
    pixel_valid_i <= 1'b0;
    gray_pixel_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest image through clamped width and height, a saturating
    // gradient just above the threshold, then the same one at the threshold.
    write_cfg(16'd0, 16'd2, 16'd254);
    foreach (corner_step[i]) send_pixel(corner_step[i]);
    pixel_valid_i <= 1'b0;
    settle();
    write_cfg(16'd1, 16'd0, 16'd255);
    foreach (corner_step[i]) send_pixel(corner_step[i]);
    pixel_valid_i <= 1'b0;
    settle();

    while (items_sent < ITEM_TARGET + (big_done ? 3 * MAXW : 0)) begin
      wd = CFG_DATA_W'($urandom);
      hd = CFG_DATA_W'($urandom_range(3, 10));
      td = CFG_DATA_W'($urandom);
      if (!big_done && items_sent >= ITEM_TARGET / 2) begin
        // all width bits set: clamps to the widest row
        wd[CFG_WIDTH_W-1:0] = '1;
        hd = CFG_DATA_W'($urandom_range(0, 3));
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0:       w_pick = $urandom_range(0, 2);
          1:       w_pick = 3;
          2:       w_pick = $urandom_range(41, 90);
          default: w_pick = $urandom_range(4, 40);
        endcase
        wd[CFG_WIDTH_W-1:0] = CFG_WIDTH_W'(w_pick);
        if ($urandom_range(0, 7) == 0) hd = CFG_DATA_W'($urandom_range(0, 2));
        else if ($urandom_range(0, 15) == 0) hd = CFG_DATA_W'($urandom_range(20, 60));
      end
      case ($urandom_range(0, 5))
        0:       td[7:0] = 8'd0;
        1:       td[7:0] = 8'd255;
        2:       ;
        default: td[7:0] = 8'($urandom_range(0, 120));
      endcase
      case ($urandom_range(0, 2))
        0:       tx_idle_max = 0;
        1:       tx_idle_max = 12;
        default: tx_idle_max = $urandom_range(1, 12);
      endcase
      write_cfg(wd, hd, td);
      run_frame(wd, hd, $urandom_range(PIX_UNIFORM, PIX_BINARY));
      settle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("sobel_edge_magnitude_threshold_unit_tb: done, clean");
    else
      $display("sobel_edge_magnitude_threshold_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- sobel_edge_magnitude_threshold_unit.f -----
rtl/sem_pkg.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude_threshold_unit.sv
rtl/sem_checker.sv
tb/sv/sobel_edge_magnitude_threshold_unit_tb.sv
